// File: rtl/core/pfm_pkg.sv
// Shared types, constants and a helper function for the polynomial fingerprint block.
package pfm_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 6;
    localparam int MOD_MAX_W  = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int GRP_N      = 4;
    localparam int GRP_IDX_W  = 3;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_MODULUS = 1'b0;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        cnt_t bit_cnt;
        cnt_t degree;
    } step_ctrl_t;

    // Index of the highest set bit of one byte, zero when the byte is zero.
    function automatic logic [GRP_IDX_W-1:0] grp_hi(input logic [BYTE_W-1:0] b);
        logic [GRP_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 1; i < BYTE_W; i++)
        begin
            if (b[i])
            begin
                idx = GRP_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/polynomial_fingerprint_mod_top.sv
// Top level of the polynomial fingerprint block: handshake, registers and APB port.
// A message's fingerprint passes through the input register and then the result register.
// Throughput: one word per cycle unless src_stall is raised; the eight bit steps of a byte are combinational.
// After a modulus write the input stalls in SCAN_GROUP and SCAN_DONE while the degree is found.
// Reset (rst_n, asynchronous, active low) loads modulus x + 1 and clears the message.
// Writing the modulus also restarts the message state.
module polynomial_fingerprint_mod_top #(
    parameter int POLY_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    output logic                              src_stall,
    input  logic [pfm_pkg::BYTE_W-1:0]        data_byte,
    input  logic                              last_byte,
    output logic                              fp_valid,
    input  logic                              fp_stall,
    output logic [31:0]                       fingerprint,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pfm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pfm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import pfm_pkg::*;

    localparam int MOD_W = (POLY_WIDTH < MOD_MAX_W) ? POLY_WIDTH : MOD_MAX_W;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_GROUP,
        SCAN_DONE
    } scan_state_t;

    scan_state_t            scan_reg, scan_next;
    logic [MOD_W-1:0]       mod_reg, mod_next;
    logic [GRP_N-1:0]       grp_any_reg, grp_any_next;
    logic [GRP_IDX_W-1:0]   grp_idx_reg [GRP_N];
    logic [GRP_IDX_W-1:0]   grp_idx_next [GRP_N];
    cnt_t                   deg_reg, deg_next;
    logic [POLY_WIDTH-1:0]  top_reg, top_next;
    logic [POLY_WIDTH-1:0]  red_reg, red_next;
    logic [POLY_WIDTH-1:0]  pt_init_reg, pt_init_next;
    logic [POLY_WIDTH-1:0]  residue_reg, residue_next;
    logic [POLY_WIDTH-1:0]  pt_reg, pt_next;
    cnt_t                   cnt_reg, cnt_next;
    logic                   in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0]      in_byte_reg, in_byte_next;
    logic                   in_last_reg, in_last_next;
    logic                   out_vld_reg, out_vld_next;
    logic [31:0]            fp_reg, fp_next;

    step_ctrl_t             step_ctrl;
    logic [POLY_WIDTH-1:0]  residue_step;
    logic [POLY_WIDTH-1:0]  pt_step;
    cnt_t                   cnt_step;
    logic                   wr_en;
    logic                   adv;
    cnt_t                   deg_comb;
    logic [POLY_WIDTH-1:0]  top_comb;
    logic [MOD_MAX_W-1:0]   mod_wide;

    assign step_ctrl.bit_cnt = cnt_reg;
    assign step_ctrl.degree  = deg_reg;

    pfm_byte_step #(
        .POLY_WIDTH (POLY_WIDTH)
    ) u_step (
        .ctrl        (step_ctrl),
        .data_byte   (in_byte_reg),
        .residue     (residue_reg),
        .power       (pt_reg),
        .top         (top_reg),
        .reducer     (red_reg),
        .residue_out (residue_step),
        .power_out   (pt_step),
        .bit_cnt_out (cnt_step)
    );

    assign wr_en    = psel && penable && pwrite && (paddr[2] == REG_MODULUS);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MODULUS) ? APB_DATA_W'(mod_reg) : '0;
    assign mod_wide = MOD_MAX_W'(mod_reg);

    // A last word may only leave the input register when the result register frees up.
    assign adv       = in_vld_reg && (!in_last_reg || !out_vld_reg || !fp_stall);
    assign src_stall = (scan_reg != SCAN_IDLE) || (in_vld_reg && !adv);

    assign fp_valid    = out_vld_reg;
    assign fingerprint = fp_reg;

    always_comb
    begin
        deg_comb = '0;
        for (int g = 0; g < GRP_N; g++)
        begin
            if (grp_any_reg[g])
            begin
                deg_comb = cnt_t'({2'(g), grp_idx_reg[g]});
            end
        end
        top_comb = POLY_WIDTH'(1) << deg_comb;
    end

    always_comb
    begin
        scan_next    = scan_reg;
        mod_next     = mod_reg;
        grp_any_next = grp_any_reg;
        grp_idx_next = grp_idx_reg;
        deg_next     = deg_reg;
        top_next     = top_reg;
        red_next     = red_reg;
        pt_init_next = pt_init_reg;
        residue_next = residue_reg;
        pt_next      = pt_reg;
        cnt_next     = cnt_reg;
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        in_last_next = in_last_reg;
        out_vld_next = out_vld_reg;
        fp_next      = fp_reg;

        if (!src_stall)
        begin
            in_vld_next  = src_valid;
            in_byte_next = data_byte;
            in_last_next = last_byte;
        end

        if (adv && in_last_reg)
        begin
            out_vld_next = 1'b1;
            fp_next      = 32'(residue_step);
        end
        else if (!fp_stall)
        begin
            out_vld_next = 1'b0;
        end

        if (adv)
        begin
            if (in_last_reg)
            begin
                residue_next = '0;
                cnt_next     = '0;
                pt_next      = pt_init_reg;
            end
            else
            begin
                residue_next = residue_step;
                cnt_next     = cnt_step;
                pt_next      = pt_step;
            end
        end

        case (scan_reg)
            SCAN_IDLE:
            begin
                scan_next = SCAN_IDLE;
            end
            SCAN_GROUP:
            begin
                // Highest set bit of each byte of the modulus, combined next cycle.
                for (int g = 0; g < GRP_N; g++)
                begin
                    grp_any_next[g] = (mod_wide[g*BYTE_W +: BYTE_W] != '0);
                    grp_idx_next[g] = grp_hi(mod_wide[g*BYTE_W +: BYTE_W]);
                end
                scan_next = SCAN_DONE;
            end
            SCAN_DONE:
            begin
                deg_next     = deg_comb;
                top_next     = top_comb;
                red_next     = POLY_WIDTH'(mod_reg) | top_comb;
                pt_init_next = POLY_WIDTH'(mod_reg) & ~top_comb;
                pt_next      = POLY_WIDTH'(mod_reg) & ~top_comb;
                residue_next = '0;
                cnt_next     = '0;
                scan_next    = SCAN_IDLE;
            end
            default:
            begin
                scan_next = SCAN_IDLE;
            end
        endcase

        if (wr_en)
        begin
            mod_next  = pwdata[MOD_W-1:0];
            scan_next = SCAN_GROUP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg    <= SCAN_IDLE;
            mod_reg     <= MOD_W'(3);
            grp_any_reg <= '0;
            for (int g = 0; g < GRP_N; g++)
            begin
                grp_idx_reg[g] <= '0;
            end
            deg_reg     <= cnt_t'(1);
            top_reg     <= POLY_WIDTH'(2);
            red_reg     <= POLY_WIDTH'(3);
            pt_init_reg <= POLY_WIDTH'(1);
            residue_reg <= '0;
            pt_reg      <= POLY_WIDTH'(1);
            cnt_reg     <= '0;
            in_vld_reg  <= 1'b0;
            in_byte_reg <= '0;
            in_last_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            fp_reg      <= '0;
        end
        else
        begin
            scan_reg    <= scan_next;
            mod_reg     <= mod_next;
            grp_any_reg <= grp_any_next;
            grp_idx_reg <= grp_idx_next;
            deg_reg     <= deg_next;
            top_reg     <= top_next;
            red_reg     <= red_next;
            pt_init_reg <= pt_init_next;
            residue_reg <= residue_next;
            pt_reg      <= pt_next;
            cnt_reg     <= cnt_next;
            in_vld_reg  <= in_vld_next;
            in_byte_reg <= in_byte_next;
            in_last_reg <= in_last_next;
            out_vld_reg <= out_vld_next;
            fp_reg      <= fp_next;
        end
    end

`ifndef SYNTH
    a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_reg != SCAN_IDLE) |-> src_stall)
        else $error("input not stalled during degree scan");

    a_count_within_degree: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= deg_reg)
        else $error("bit count ran past the degree");

    a_power_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_reg & ~(top_reg - POLY_WIDTH'(1))) == '0)
        else $error("power term not reduced below the top bit");

    a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (residue_reg & ~(top_reg - POLY_WIDTH'(1))) == '0)
        else $error("residue not reduced below the top bit");

    a_last_word_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_last_reg) |=> fp_valid)
        else $error("last word did not produce a fingerprint");
`endif

endmodule

// File: rtl/core/pfm_byte_step.sv
// Eight unrolled bit steps that fold one message byte into the residue.
module pfm_byte_step #(
    parameter int POLY_WIDTH = 32
) (
    input  pfm_pkg::step_ctrl_t                ctrl,
    input  logic [pfm_pkg::BYTE_W-1:0]         data_byte,
    input  logic [POLY_WIDTH-1:0]              residue,
    input  logic [POLY_WIDTH-1:0]              power,
    input  logic [POLY_WIDTH-1:0]              top,
    input  logic [POLY_WIDTH-1:0]              reducer,
    output logic [POLY_WIDTH-1:0]              residue_out,
    output logic [POLY_WIDTH-1:0]              power_out,
    output pfm_pkg::cnt_t                      bit_cnt_out
);
    import pfm_pkg::*;

    always_comb
    begin
        logic [POLY_WIDTH-1:0] res;
        logic [POLY_WIDTH-1:0] pwr;
        cnt_t                  cnt;
        res = residue;
        pwr = power;
        cnt = ctrl.bit_cnt;
        for (int j = 0; j < BYTE_W; j++)
        begin
            if (cnt < ctrl.degree)
            begin
                // The low bits of the message land in the residue unchanged.
                if (data_byte[j])
                begin
                    res = res | (POLY_WIDTH'(1) << cnt);
                end
                cnt = cnt + cnt_t'(1);
            end
            else
            begin
                if (data_byte[j])
                begin
                    res = res ^ pwr;
                end
                pwr = pwr << 1;
                if ((pwr & top) != '0)
                begin
                    pwr = pwr ^ reducer;
                end
            end
        end
        residue_out = res;
        power_out   = pwr;
        bit_cnt_out = cnt;
    end

endmodule
